// File: src/rsi_pkg.sv
// shared constants and types for the radix string to int64 parser
package rsi_pkg;

    localparam int ALPHABET_DEPTH = 64;
    localparam int ALPHA_IDX_W    = $clog2(ALPHABET_DEPTH);
    localparam int CHAR_W         = 8;
    localparam int BASE_W         = 7;
    localparam int VALUE_W        = 64;
    localparam int MAG_W          = VALUE_W - 1;
    localparam int PROD_W         = MAG_W + BASE_W + 1;

    typedef logic [CHAR_W-1:0]      t_char;
    typedef logic [ALPHA_IDX_W-1:0] t_alpha_idx;
    typedef logic [BASE_W-1:0]      t_base;
    typedef logic [MAG_W-1:0]       t_mag;
    typedef logic [PROD_W-1:0]      t_prod;

    localparam logic OP_PARSE       = 1'b0;
    localparam logic OP_ALPHA_WRITE = 1'b1;

    localparam t_base BASE_RESET = t_base'(10);
    localparam t_base BASE_CAP   = t_base'(ALPHABET_DEPTH);

    localparam t_char CHAR_NUL   = 8'h00;
    localparam t_char CHAR_TAB   = 8'h09;
    localparam t_char CHAR_CR    = 8'h0D;
    localparam t_char CHAR_SPACE = 8'h20;
    localparam t_char CHAR_PLUS  = 8'h2B;
    localparam t_char CHAR_MINUS = 8'h2D;

    localparam logic [VALUE_W-1:0] VALUE_MIN  = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic [VALUE_W-1:0] ALL_ONES   = {VALUE_W{1'b1}};
    localparam t_prod              PROD_MIN   = t_prod'(VALUE_MIN);

endpackage

// File: src/radix_string_to_int64.sv
// radix_string_to_int64: signed 64-bit integer parser over a loaded digit alphabet
//
// Takes one beat per cycle with no bubbles unless stalled. Alphabet writes complete as
// the beat is accepted; a character beat has its alphabet match (64 parallel compares
// and a lowest-match pick) done on the way into the input register, then the sign,
// phase, and a 63x7 multiply-add run from it into the parser state and result register.
// A result passes through the input register, then the result register, which decouples
// the two sides: if it is full and stalled and a beat waits in the input, the input stalls.
// The base register may be written only while the block is idle.
module radix_string_to_int64 (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_operation,
    input  logic [rsi_pkg::CHAR_W-1:0]       i_char_code,
    input  logic [rsi_pkg::ALPHA_IDX_W-1:0]  i_alphabet_index,
    input  logic                             i_first,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [rsi_pkg::VALUE_W-1:0] o_value,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rsi_pkg::BASE_W-1:0]       i_cfg_data
);

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    // alphabet, no reset
    rsi_pkg::t_char r_alpha [rsi_pkg::ALPHABET_DEPTH];

    rsi_pkg::t_base r_base;

    logic                  r_s1_valid;
    rsi_pkg::t_char        r_s1_char;
    logic                  r_s1_first;
    logic                  r_s1_dvalid;
    rsi_pkg::t_alpha_idx   r_s1_digit;

    t_phase                r_phase;
    logic                  r_neg;
    rsi_pkg::t_mag         r_acc;

    logic                  r_out_valid;
    logic [rsi_pkg::VALUE_W-1:0] r_out_value;

    logic                  in_accept;
    logic                  out_free;
    logic                  s1_fire;

    rsi_pkg::t_base        eff_base;
    logic [rsi_pkg::ALPHABET_DEPTH-1:0] match;
    logic [rsi_pkg::ALPHABET_DEPTH-1:0] low_match;
    rsi_pkg::t_alpha_idx   n_digit;
    logic                  n_dvalid;

    t_phase                ph_eff;
    logic                  neg_eff;
    rsi_pkg::t_mag         acc_eff;
    logic                  is_space;
    logic                  is_sign;
    rsi_pkg::t_prod        full;
    t_phase                n_phase;
    logic                  n_neg;
    rsi_pkg::t_mag         n_acc;
    logic                  s1_emit;
    logic [rsi_pkg::VALUE_W-1:0] emit_value;

    assign out_free    = !r_out_valid || !i_stall;
    assign s1_fire     = r_s1_valid && out_free;
    assign o_stall     = r_s1_valid && !out_free;
    assign in_accept   = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_value     = r_out_value;

    // alphabet match against the incoming character
    assign eff_base = (r_base > rsi_pkg::BASE_CAP) ? rsi_pkg::BASE_CAP : r_base;

    always_comb begin
        for (int i = 0; i < rsi_pkg::ALPHABET_DEPTH; i++) begin
            match[i] = (r_alpha[i] == i_char_code) && (rsi_pkg::t_base'(i) < eff_base);
        end
        low_match = match & (~match + {{(rsi_pkg::ALPHABET_DEPTH-1){1'b0}}, 1'b1});
        n_digit   = '0;
        for (int i = 0; i < rsi_pkg::ALPHABET_DEPTH; i++) begin
            if (low_match[i]) begin
                n_digit = n_digit | rsi_pkg::t_alpha_idx'(i);
            end
        end
        n_dvalid = (|match) && (i_char_code != rsi_pkg::CHAR_NUL);
    end

    // parser step
    always_comb begin
        ph_eff   = r_s1_first ? PH_SKIP : r_phase;
        neg_eff  = r_s1_first ? 1'b0 : r_neg;
        acc_eff  = r_s1_first ? '0 : r_acc;
        is_space = (r_s1_char == rsi_pkg::CHAR_SPACE) ||
                   ((r_s1_char >= rsi_pkg::CHAR_TAB) && (r_s1_char <= rsi_pkg::CHAR_CR));
        is_sign  = (r_s1_char == rsi_pkg::CHAR_PLUS) || (r_s1_char == rsi_pkg::CHAR_MINUS);
        full     = rsi_pkg::t_prod'(acc_eff) * rsi_pkg::t_prod'(eff_base)
                   + rsi_pkg::t_prod'(r_s1_digit);
        n_phase    = ph_eff;
        n_neg      = neg_eff;
        n_acc      = acc_eff;
        s1_emit    = 1'b0;
        emit_value = '0;
        case (ph_eff)
            PH_SKIP, PH_DIGITS: begin
                if (ph_eff == PH_SKIP && is_space) begin
                    n_phase = PH_SKIP;
                end else if (ph_eff == PH_SKIP && is_sign) begin
                    n_phase = PH_DIGITS;
                    n_neg   = (r_s1_char == rsi_pkg::CHAR_MINUS);
                end else if (!r_s1_dvalid) begin
                    n_phase    = PH_DONE;
                    s1_emit    = 1'b1;
                    emit_value = neg_eff ? (rsi_pkg::VALUE_W'(0) - {1'b0, acc_eff})
                                         : {1'b0, acc_eff};
                end else if (|full[rsi_pkg::PROD_W-1:rsi_pkg::MAG_W]) begin
                    // magnitude past the positive limit
                    n_phase = PH_DONE;
                    s1_emit = 1'b1;
                    if (neg_eff && full == rsi_pkg::PROD_MIN) begin
                        emit_value = rsi_pkg::VALUE_MIN;
                    end else begin
                        emit_value = neg_eff ? '0 : rsi_pkg::ALL_ONES;
                    end
                end else begin
                    n_phase = PH_DIGITS;
                    n_acc   = full[rsi_pkg::MAG_W-1:0];
                end
            end
            default: begin
                n_phase = ph_eff;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_operation == rsi_pkg::OP_ALPHA_WRITE) begin
            r_alpha[i_alphabet_index] <= i_char_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= rsi_pkg::BASE_RESET;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_SKIP;
            r_neg       <= 1'b0;
            r_acc       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_base <= i_cfg_data;
            end
            if (in_accept) begin
                r_s1_valid <= (i_operation == rsi_pkg::OP_PARSE);
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_acc   <= n_acc;
            end
            if (s1_fire && s1_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_char   <= i_char_code;
            r_s1_first  <= i_first;
            r_s1_dvalid <= n_dvalid;
            r_s1_digit  <= n_digit;
        end
        if (s1_fire && s1_emit) begin
            r_out_value <= emit_value;
        end
    end

    // blocked character beat stays in the input register
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_free |=> r_s1_valid)
        else $error("character beat dropped while blocked");

    // skip phase always starts from a clean magnitude and sign
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SKIP |-> (r_acc == '0 && !r_neg))
        else $error("stale accumulator in skip phase");

    // a result beat follows every emitting parser step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && s1_emit |=> o_valid)
        else $error("emitted result not presented");

    // a registered digit never comes from a nul byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_dvalid |-> r_s1_char != rsi_pkg::CHAR_NUL)
        else $error("nul byte matched as digit");

    // once done, only a first-marked beat restarts the parser
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DONE && s1_fire && !r_s1_first |=> r_phase == PH_DONE)
        else $error("parser left done phase without first mark");

endmodule

// File: tb/sv/radix_string_to_int64_tb.sv
// self-checking testbench for the radix string to int64 parser
`timescale 1ns / 1ps

module radix_string_to_int64_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam logic [rsi_pkg::VALUE_W-1:0] MAG_LIMIT = ~rsi_pkg::VALUE_MIN;

    typedef struct packed {
        logic                op;
        rsi_pkg::t_char      ch;
        rsi_pkg::t_alpha_idx idx;
        logic                first;
    } t_char_beat;

    typedef enum logic [1:0] {SKIP_BLANKS, IN_DIGITS, FINISHED} t_parse_phase;
    typedef enum {SEND36_RECV72, SEND72_RECV36, NO_IDLE} t_idle_mode;
    typedef enum {ALPHA_STD, ALPHA_DISTINCT, ALPHA_DUPS} t_alpha_kind;

    logic                               i_clk            = 1'b0;
    logic                               i_rst_n          = 1'b0;
    logic                               i_valid          = 1'b0;
    logic                               o_stall;
    logic                               i_operation      = rsi_pkg::OP_PARSE;
    logic [rsi_pkg::CHAR_W-1:0]         i_char_code      = '0;
    logic [rsi_pkg::ALPHA_IDX_W-1:0]    i_alphabet_index = '0;
    logic                               i_first          = 1'b0;
    logic                               o_valid;
    logic                               i_stall          = 1'b0;
    logic signed [rsi_pkg::VALUE_W-1:0] o_value;
    logic                               i_cfg_valid      = 1'b0;
    logic                               o_cfg_ready;
    logic [rsi_pkg::BASE_W-1:0]         i_cfg_data       = '0;

    radix_string_to_int64 dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_char_code     (i_char_code),
        .i_alphabet_index(i_alphabet_index),
        .i_first         (i_first),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_value         (o_value),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // parser copy kept by the testbench
    rsi_pkg::t_char              alpha_copy [rsi_pkg::ALPHABET_DEPTH];
    t_parse_phase                pstate    = SKIP_BLANKS;
    bit                          neg_sign  = 1'b0;
    logic [rsi_pkg::VALUE_W-1:0] magnitude = '0;
    rsi_pkg::t_base              base_now  = rsi_pkg::BASE_RESET;

    logic [rsi_pkg::VALUE_W-1:0] expected_values [$];
    t_char_beat                  beat_q [$];
    t_char_beat                  offered;
    rsi_pkg::t_char              gen_alpha [rsi_pkg::ALPHABET_DEPTH];
    bit                          next_first;

    t_idle_mode idle_mode  = SEND36_RECV72;
    bit         send_gap;
    bit         hold_go    = 1'b0;
    bit         hold_begun = 1'b0;
    int         hold_left  = 0;
    int         quiet      = 0;

    int n_queued   = 0;
    int n_accepted = 0;
    int n_values   = 0;
    int n_errors   = 0;
    int n_cfg      = 0;
    logic [rsi_pkg::VALUE_W-1:0] want;

    function automatic void parse_step(input t_char_beat b);
        int          eb;
        int          dig;
        logic [71:0] prod;
        if (b.op == rsi_pkg::OP_ALPHA_WRITE) begin
            alpha_copy[b.idx] = b.ch;
            return;
        end
        if (b.first) begin
            pstate    = SKIP_BLANKS;
            neg_sign  = 1'b0;
            magnitude = '0;
        end
        if (pstate == FINISHED)
            return;
        if (pstate == SKIP_BLANKS) begin
            if (b.ch == rsi_pkg::CHAR_SPACE ||
                (b.ch >= rsi_pkg::CHAR_TAB && b.ch <= rsi_pkg::CHAR_CR))
                return;
            pstate = IN_DIGITS;
            if (b.ch == rsi_pkg::CHAR_PLUS || b.ch == rsi_pkg::CHAR_MINUS) begin
                neg_sign = (b.ch == rsi_pkg::CHAR_MINUS);
                return;
            end
        end
        eb  = (base_now > rsi_pkg::ALPHABET_DEPTH) ? rsi_pkg::ALPHABET_DEPTH
                                                    : int'(base_now);
        dig = -1;
        if (b.ch != rsi_pkg::CHAR_NUL) begin
            for (int i = eb - 1; i >= 0; i--)
                if (alpha_copy[i] == b.ch)
                    dig = i;
        end
        if (dig < 0) begin
            expected_values.push_back(neg_sign ? (rsi_pkg::VALUE_W'(0) - magnitude)
                                               : magnitude);
            pstate = FINISHED;
            return;
        end
        prod = 72'(magnitude) * 72'(eb) + 72'(dig);
        if (prod > 72'(MAG_LIMIT)) begin
            if (neg_sign && prod == 72'(rsi_pkg::VALUE_MIN))
                expected_values.push_back(rsi_pkg::VALUE_MIN);
            else
                expected_values.push_back(neg_sign ? '0 : rsi_pkg::ALL_ONES);
            pstate = FINISHED;
        end else begin
            magnitude = prod[rsi_pkg::VALUE_W-1:0];
        end
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                parse_step(offered);
                n_accepted++;
            end
            if (!i_valid || !o_stall) begin
                send_gap = (idle_mode == SEND36_RECV72) ? ($urandom_range(99) < 36) :
                           (idle_mode == SEND72_RECV36) ? ($urandom_range(99) < 72) : 1'b0;
                if (beat_q.size() != 0 && !send_gap) begin
                    offered = beat_q.pop_front();
                    i_valid          <= 1'b1;
                    i_operation      <= offered.op;
                    i_char_code      <= offered.ch;
                    i_alphabet_index <= offered.idx;
                    i_first          <= offered.first;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_go && !hold_begun) begin
            hold_begun = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (idle_mode == SEND36_RECV72) begin
            i_stall <= ($urandom_range(99) < 72);
        end else if (idle_mode == SEND72_RECV36) begin
            i_stall <= ($urandom_range(99) < 36);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // result check
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            n_values++;
            if (expected_values.size() == 0) begin
                n_errors++;
                if (n_errors <= 20)
                    $display("%0t unexpected value: expected none, got %0d",
                             $time, o_value);
            end else begin
                want = expected_values.pop_front();
                if (o_value !== want) begin
                    n_errors++;
                    if (n_errors <= 20)
                        $display("%0t value mismatch: expected %0d, got %0d",
                                 $time, $signed(want), o_value);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no beat moved for %0d cycles", $time, quiet);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_beat(input logic op, input rsi_pkg::t_char ch,
                             input rsi_pkg::t_alpha_idx idx, input logic first);
        t_char_beat b;
        b = '{op, ch, idx, first};
        beat_q.push_back(b);
        n_queued++;
    endtask

    task automatic push_parse(input rsi_pkg::t_char ch);
        push_beat(rsi_pkg::OP_PARSE, ch,
                  rsi_pkg::t_alpha_idx'($urandom_range(rsi_pkg::ALPHABET_DEPTH - 1)),
                  next_first);
        next_first = 1'b0;
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_parse(rsi_pkg::t_char'(s[i]));
    endtask

    task automatic push_alpha(input int idx, input rsi_pkg::t_char ch);
        gen_alpha[idx] = ch;
        push_beat(rsi_pkg::OP_ALPHA_WRITE, ch, rsi_pkg::t_alpha_idx'(idx),
                  logic'($urandom_range(1)));
    endtask

    task automatic load_alphabet(input t_alpha_kind kind);
        rsi_pkg::t_char ch;
        bit             taken [256];
        for (int i = 0; i < rsi_pkg::ALPHABET_DEPTH; i++) begin
            case (kind)
                ALPHA_STD: begin
                    if (i < 10)
                        ch = rsi_pkg::t_char'(8'h30 + i);
                    else if (i < 36)
                        ch = rsi_pkg::t_char'(8'h61 + i - 10);
                    else if (i < 62)
                        ch = rsi_pkg::t_char'(8'h41 + i - 36);
                    else
                        ch = (i == 62) ? rsi_pkg::CHAR_PLUS : rsi_pkg::CHAR_MINUS;
                end
                ALPHA_DISTINCT: begin
                    do ch = rsi_pkg::t_char'($urandom_range(255, 1)); while (taken[ch]);
                    taken[ch] = 1'b1;
                end
                default: begin
                    if (i > 0 && $urandom_range(2) == 0)
                        ch = gen_alpha[$urandom_range(i - 1)];
                    else
                        ch = rsi_pkg::t_char'($urandom_range(255));
                end
            endcase
            push_alpha(i, ch);
        end
    endtask

    // one string: blanks, sign, digits, then an end byte unless cut short
    task automatic push_number(input bit cut, output int used);
        int                          eb;
        int                          kind;
        int                          sign;
        int                          n;
        int                          start;
        bit                          hit;
        logic [rsi_pkg::VALUE_W-1:0] mag;
        rsi_pkg::t_char              ch;
        rsi_pkg::t_char              digs [$];
        start = n_queued;
        eb    = (base_now > rsi_pkg::ALPHABET_DEPTH) ? rsi_pkg::ALPHABET_DEPTH
                                                      : int'(base_now);
        kind  = $urandom_range(9);
        next_first = 1'b1;
        n = $urandom_range(2);
        for (int i = 0; i < n; i++)
            push_parse(($urandom_range(5) == 0) ? rsi_pkg::CHAR_SPACE
                       : rsi_pkg::t_char'(rsi_pkg::CHAR_TAB + $urandom_range(4)));
        sign = (kind >= 8) ? ($urandom_range(1) ? 2 : 0) : $urandom_range(2);
        if (sign == 1)
            push_parse(rsi_pkg::CHAR_PLUS);
        else if (sign == 2)
            push_parse(rsi_pkg::CHAR_MINUS);
        if (kind >= 8 && eb >= 2) begin
            case ($urandom_range(5))
                0: mag = MAG_LIMIT;
                1: mag = rsi_pkg::VALUE_MIN;
                2: mag = rsi_pkg::VALUE_MIN + 1;
                3: mag = MAG_LIMIT - 1;
                4: mag = rsi_pkg::ALL_ONES;
                default: mag = {$urandom, $urandom};
            endcase
            do begin
                digs.push_front(gen_alpha[mag % eb]);
                mag = mag / eb;
            end while (mag != 0);
            foreach (digs[i])
                push_parse(digs[i]);
        end else if (eb >= 1) begin
            n = (kind >= 6) ? $urandom_range(25, 12) : $urandom_range(6);
            for (int i = 0; i < n; i++)
                push_parse(gen_alpha[$urandom_range(eb - 1)]);
        end
        if (!cut) begin
            do begin
                case ($urandom_range(3))
                    0:       ch = rsi_pkg::CHAR_NUL;
                    1:       ch = rsi_pkg::CHAR_SPACE;
                    default: ch = rsi_pkg::t_char'($urandom_range(255));
                endcase
                hit = 1'b0;
                for (int i = 0; i < eb; i++)
                    if (ch != rsi_pkg::CHAR_NUL && gen_alpha[i] == ch)
                        hit = 1'b1;
            end while (hit);
            push_parse(ch);
        end
        used = n_queued - start;
        // trailing bytes after the end are ignored
        n = cut ? 0 : $urandom_range(2);
        for (int i = 0; i < n; i++)
            push_parse(rsi_pkg::t_char'($urandom_range(255)));
    endtask

    task automatic random_phase(input int target);
        int done;
        int used;
        int pick;
        done = 0;
        while (done < target) begin
            pick = $urandom_range(99);
            if (pick < 72) begin
                push_number(1'b0, used);
                done += used;
            end else if (pick < 84) begin
                push_number(1'b1, used);
                done += used;
            end else if (pick < 94) begin
                repeat ($urandom_range(4, 1))
                    push_beat(rsi_pkg::OP_PARSE, rsi_pkg::t_char'($urandom_range(255)),
                              rsi_pkg::t_alpha_idx'($urandom_range(
                                  rsi_pkg::ALPHABET_DEPTH - 1)),
                              logic'($urandom_range(1)));
            end else begin
                push_alpha($urandom_range(rsi_pkg::ALPHABET_DEPTH - 1),
                           rsi_pkg::t_char'($urandom_range(255)));
            end
        end
    endtask

    // drain: all beats in, all values out, then the pipeline latency
    task automatic wait_idle();
        while (n_accepted != n_queued || expected_values.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_base(input rsi_pkg::t_base v);
        wait_idle();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        base_now = v;
        n_cfg++;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_base(rsi_pkg::t_base'(10));
        load_alphabet(ALPHA_STD);

        // directed strings
        next_first = 1'b1;
        push_parse(rsi_pkg::CHAR_TAB);
        push_str("\r +7");
        push_parse(rsi_pkg::CHAR_NUL);
        next_first = 1'b1;
        push_str("--");
        next_first = 1'b1;
        push_parse(8'hFF);
        push_str("5");
        next_first = 1'b1;
        push_str("\v\n\f-90;");
        next_first = 1'b1;
        push_str("12");
        next_first = 1'b1;
        push_str("4 ");
        next_first = 1'b1;
        push_str("5");
        push_beat(rsi_pkg::OP_ALPHA_WRITE, rsi_pkg::CHAR_MINUS,
                  rsi_pkg::t_alpha_idx'(rsi_pkg::ALPHABET_DEPTH - 1), 1'b1);
        push_str("6z");

        random_phase(320);
        wait_idle();
        idle_mode = SEND72_RECV36;
        write_base(rsi_pkg::BASE_CAP);
        random_phase(320);
        wait_idle();
        idle_mode = NO_IDLE;
        write_base(rsi_pkg::t_base'(2));
        random_phase(180);
        write_base(rsi_pkg::t_base'(16));
        hold_go = 1'b1;
        random_phase(140);
        write_base(rsi_pkg::t_base'(36));
        load_alphabet(ALPHA_DISTINCT);
        random_phase(140);
        load_alphabet(ALPHA_DUPS);
        random_phase(70);
        write_base(rsi_pkg::t_base'(127));
        random_phase(45);
        write_base(rsi_pkg::t_base'(1));
        random_phase(30);
        write_base(rsi_pkg::t_base'(0));
        random_phase(30);
        write_base(rsi_pkg::BASE_CAP);
        load_alphabet(ALPHA_STD);
        random_phase(45);
        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("summary: %0d beats in, %0d values checked, %0d base writes", n_accepted,
                 n_values, n_cfg);
        $display("summary: bases 0, 1, 2, 10, 16, 36, 64, 127 with fixed, %s",
                 "distinct and duplicate alphabets");
        if (n_errors == 0 && expected_values.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d errors, %0d values still expected", n_errors,
                     expected_values.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule
